// ===== rtl/imu_bcs_pkg.sv =====
// Shared widths, controller states, register indexes and the command and
// status structs that join the controller and datapath of the IMU unit.
// No dependencies.
`default_nettype none

package imu_bcs_pkg;

   localparam int SAMPLE_W  = 16;                // raw sensor reading
   localparam int FRAC_W    = 8;                 // fraction bits of the outputs
   localparam int COUNT_W   = 12;                // calibration sample counter
   localparam int OUT_W     = SAMPLE_W + FRAC_W; // Q16.8 result
   localparam int SUM_W     = SAMPLE_W + COUNT_W;
   localparam int DVD_W     = SUM_W + FRAC_W;    // scaled bias dividend
   localparam int ALPHA_W   = 17;                // Q1.16 weight, up to 1.0
   localparam int ALPHA_FRAC = 16;
   localparam int DIFF_W    = OUT_W + 1;
   localparam int PROD_W    = DIFF_W + ALPHA_W + 1;
   localparam int SAT_W     = PROD_W - ALPHA_FRAC;
   localparam int AXES      = 3;
   localparam int LANES     = 2 * AXES;          // accel x/y/z then rate x/y/z
   localparam int AXIS_W    = $clog2(LANES);
   localparam int STEP_W    = $clog2(DVD_W);
   localparam int CSR_AW    = 2;
   localparam int CSR_DW    = ALPHA_W;
   localparam int REQ_DW    = 3 * AXES * SAMPLE_W;
   localparam int RSP_DW    = 2 * AXES * OUT_W + AXES * SAMPLE_W;

   localparam logic [ALPHA_W-1:0] ALPHA_ONE    = ALPHA_W'(1 << ALPHA_FRAC);
   localparam logic [COUNT_W-1:0] CALIB_RESET  = COUNT_W'(500);

   localparam logic [CSR_AW-1:0] CSR_ALPHA_ACCEL   = 2'd0;
   localparam logic [CSR_AW-1:0] CSR_ALPHA_RATE    = 2'd1;
   localparam logic [CSR_AW-1:0] CSR_CALIB_SAMPLES = 2'd2;
   localparam logic [CSR_AW-1:0] CSR_HAS_MAG       = 2'd3;

   localparam logic CMD_CALIBRATE = 1'b0;
   localparam logic CMD_MEASURE   = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PREP,
      ST_MUL,
      ST_ACC,
      ST_CAL,
      ST_CHECK,
      ST_DIV,
      ST_BIAS,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic              capture;
      logic              prep;
      logic              mul;
      logic              acc;
      logic              cal_add;
      logic              div_load;
      logic              div_step;
      logic              bias_write;
      logic              out_load;
      logic [AXIS_W-1:0] axis;
   } ctrl_cmd_type;

   typedef struct packed {
      logic cmd_in;
      logic reached;
      logic rsp_busy;
   } ctrl_status_type;

endpackage

`default_nettype wire

// ===== rtl/imu_bias_calibrate_and_smooth_unit.sv =====
// From request accept to rsp_tvalid, a measure request runs PREP, then MUL and ACC
// for each of six lanes through one shared multiplier, then FINISH; a calibrate
// request runs CAL, CHECK and FINISH, with the 36-step divider (DIV) and BIAS before
// FINISH when it completes the bias average. One request at a time, taken the cycle
// after its result is loaded; a stalled result holds the following request in FINISH.
// Reset (synchronous, active high) clears sums, count, bias, filter state and magnetometer.
`default_nettype none

module imu_bias_calibrate_and_smooth_unit (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_we,
   input  wire logic [imu_bcs_pkg::CSR_AW-1:0]      csr_addr,
   input  wire logic [imu_bcs_pkg::CSR_DW-1:0]      csr_wdata,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // accel_x, accel_y, accel_z, rate_x, rate_y, rate_z, field_x, field_y, field_z
   input  wire logic [imu_bcs_pkg::REQ_DW-1:0]      req_tdata,
   // cmd
   input  wire logic                                req_tuser,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // smooth_accel_x/y/z, smooth_rate_x/y/z, mag_out_x, mag_out_y, mag_out_z
   output logic [imu_bcs_pkg::RSP_DW-1:0]           rsp_tdata,
   // calib_done
   output logic                                     rsp_tuser
);

   imu_bcs_pkg::ctrl_cmd_type    cmd;
   imu_bcs_pkg::ctrl_status_type status;

   imu_bcs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   imu_bcs_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata),
      .cmd        (cmd),
      .status     (status)
   );

endmodule

`default_nettype wire

// ===== rtl/imu_bcs_div_lane.sv =====
// One lane of the bias divider: restoring division, one quotient bit per
// step, of the scaled bias sum magnitude by the sample count. Uses imu_bcs_pkg.
`default_nettype none

module imu_bcs_div_lane (
   input  wire logic                           clock,
   input  wire logic                           load,
   input  wire logic                           step,
   input  wire logic [imu_bcs_pkg::DVD_W-1:0]  dividend,
   input  wire logic [imu_bcs_pkg::COUNT_W-1:0] divisor,
   output logic [imu_bcs_pkg::DVD_W-1:0]       quotient
);

   logic [imu_bcs_pkg::COUNT_W-1:0] rem_ff, rem_in;
   logic [imu_bcs_pkg::COUNT_W-1:0] div_ff, div_in;
   logic [imu_bcs_pkg::DVD_W-1:0]   quo_ff, quo_in;
   logic [imu_bcs_pkg::COUNT_W:0]   trial;
   logic                            fits;

   always_comb begin
      trial  = {rem_ff, quo_ff[imu_bcs_pkg::DVD_W-1]};
      fits   = trial >= {1'b0, div_ff};
      rem_in = rem_ff;
      quo_in = quo_ff;
      div_in = div_ff;
      if (load) begin
         rem_in = '0;
         quo_in = dividend;
         div_in = divisor;
      end else if (step) begin
         rem_in = fits ? imu_bcs_pkg::COUNT_W'(trial - {1'b0, div_ff})
                       : trial[imu_bcs_pkg::COUNT_W-1:0];
         quo_in = {quo_ff[imu_bcs_pkg::DVD_W-2:0], fits};
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
   end

   assign quotient = quo_ff;

endmodule

`default_nettype wire

// ===== rtl/imu_bcs_ctrl.sv =====
// Controller of the IMU unit: sequences capture, filtering over the six
// lanes, calibration accumulate, bias division and result hand-off.
// Uses imu_bcs_pkg.
`default_nettype none

module imu_bcs_ctrl (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_tvalid,
   output logic                              req_tready,
   input  wire imu_bcs_pkg::ctrl_status_type status,
   output imu_bcs_pkg::ctrl_cmd_type         cmd
);

   imu_bcs_pkg::state_type          state_ff, state_in;
   logic [imu_bcs_pkg::AXIS_W-1:0]  axis_ff, axis_in;
   logic [imu_bcs_pkg::STEP_W-1:0]  step_ff, step_in;
   logic                            last_axis;
   logic                            last_step;

   assign last_axis = axis_ff == imu_bcs_pkg::AXIS_W'(imu_bcs_pkg::LANES - 1);
   assign last_step = step_ff == imu_bcs_pkg::STEP_W'(imu_bcs_pkg::DVD_W - 1);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         imu_bcs_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               state_in = (status.cmd_in == imu_bcs_pkg::CMD_MEASURE)
                          ? imu_bcs_pkg::ST_PREP : imu_bcs_pkg::ST_CAL;
            end
         end
         imu_bcs_pkg::ST_PREP:  state_in = imu_bcs_pkg::ST_MUL;
         imu_bcs_pkg::ST_MUL:   state_in = imu_bcs_pkg::ST_ACC;
         imu_bcs_pkg::ST_ACC: begin
            state_in = last_axis ? imu_bcs_pkg::ST_FINISH : imu_bcs_pkg::ST_MUL;
         end
         imu_bcs_pkg::ST_CAL:   state_in = imu_bcs_pkg::ST_CHECK;
         imu_bcs_pkg::ST_CHECK: begin
            state_in = status.reached ? imu_bcs_pkg::ST_DIV : imu_bcs_pkg::ST_FINISH;
         end
         imu_bcs_pkg::ST_DIV: begin
            if (last_step) state_in = imu_bcs_pkg::ST_BIAS;
         end
         imu_bcs_pkg::ST_BIAS:  state_in = imu_bcs_pkg::ST_FINISH;
         imu_bcs_pkg::ST_FINISH: begin
            if (!status.rsp_busy) state_in = imu_bcs_pkg::ST_IDLE;
         end
         default: state_in = imu_bcs_pkg::ST_IDLE;
      endcase
   end

   // lane and divider step counters
   always_comb begin
      axis_in = axis_ff;
      step_in = step_ff;
      unique case (state_ff)
         imu_bcs_pkg::ST_PREP:  axis_in = '0;
         imu_bcs_pkg::ST_ACC:   axis_in = axis_ff + 1'b1;
         imu_bcs_pkg::ST_CHECK: step_in = '0;
         imu_bcs_pkg::ST_DIV:   step_in = step_ff + 1'b1;
         default: begin
            axis_in = axis_ff;
            step_in = step_ff;
         end
      endcase
   end

   // outputs
   always_comb begin
      cmd        = '0;
      cmd.axis   = axis_ff;
      req_tready = 1'b0;
      unique case (state_ff)
         imu_bcs_pkg::ST_IDLE: begin
            // hold off requests while reset is applied
            req_tready  = !reset;
            cmd.capture = req_tvalid && !reset;
         end
         imu_bcs_pkg::ST_PREP:   cmd.prep       = 1'b1;
         imu_bcs_pkg::ST_MUL:    cmd.mul        = 1'b1;
         imu_bcs_pkg::ST_ACC:    cmd.acc        = 1'b1;
         imu_bcs_pkg::ST_CAL:    cmd.cal_add    = 1'b1;
         imu_bcs_pkg::ST_CHECK:  cmd.div_load   = status.reached;
         imu_bcs_pkg::ST_DIV:    cmd.div_step   = 1'b1;
         imu_bcs_pkg::ST_BIAS:   cmd.bias_write = 1'b1;
         imu_bcs_pkg::ST_FINISH: cmd.out_load   = !status.rsp_busy;
         default:                cmd            = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= imu_bcs_pkg::ST_IDLE;
         axis_ff  <= '0;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         axis_ff  <= axis_in;
         step_ff  <= step_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_step_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == imu_bcs_pkg::ST_DIV) |-> (step_ff < imu_bcs_pkg::STEP_W'(imu_bcs_pkg::DVD_W)))
      else $error("divider step count out of range");

   a_axis_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == imu_bcs_pkg::ST_MUL || state_ff == imu_bcs_pkg::ST_ACC)
      |-> (axis_ff < imu_bcs_pkg::AXIS_W'(imu_bcs_pkg::LANES)))
      else $error("filter lane index out of range");

   a_div_entry: assert property (@(posedge clock) disable iff (reset)
      (state_ff == imu_bcs_pkg::ST_DIV && step_ff == '0)
      |-> ($past(state_ff) == imu_bcs_pkg::ST_CHECK))
      else $error("division started without a count check");
`endif

endmodule

`default_nettype wire

// ===== rtl/imu_bcs_datapath.sv =====
// Datapath of the IMU unit: configuration registers, captured request,
// bias accumulators and divider lanes, shared filter multiplier and the
// result register. Uses imu_bcs_pkg and imu_bcs_div_lane.
`default_nettype none

module imu_bcs_datapath (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_we,
   input  wire logic [imu_bcs_pkg::CSR_AW-1:0]   csr_addr,
   input  wire logic [imu_bcs_pkg::CSR_DW-1:0]   csr_wdata,
   input  wire logic                             req_tuser,
   input  wire logic [imu_bcs_pkg::REQ_DW-1:0]   req_tdata,
   input  wire logic                             rsp_tready,
   output logic                                  rsp_tvalid,
   output logic                                  rsp_tuser,
   output logic [imu_bcs_pkg::RSP_DW-1:0]        rsp_tdata,
   input  wire imu_bcs_pkg::ctrl_cmd_type        cmd,
   output imu_bcs_pkg::ctrl_status_type          status
);

   localparam int SW = imu_bcs_pkg::SAMPLE_W;
   localparam int OW = imu_bcs_pkg::OUT_W;
   localparam int FW = imu_bcs_pkg::FRAC_W;
   localparam int AX = imu_bcs_pkg::AXES;
   localparam int LN = imu_bcs_pkg::LANES;
   localparam int BW = imu_bcs_pkg::DVD_W + 1;

   function automatic logic [OW-1:0] sat_out(input logic [imu_bcs_pkg::SAT_W-1:0] v);
      logic fits;
      fits = (v[imu_bcs_pkg::SAT_W-1:OW-1] == '0) || (v[imu_bcs_pkg::SAT_W-1:OW-1] == '1);
      if (fits) return v[OW-1:0];
      return v[imu_bcs_pkg::SAT_W-1] ? {1'b1, {(OW-1){1'b0}}} : {1'b0, {(OW-1){1'b1}}};
   endfunction

   function automatic logic [OW-1:0] sat_bias(input logic [BW-1:0] v);
      logic fits;
      fits = (v[BW-1:OW-1] == '0) || (v[BW-1:OW-1] == '1);
      if (fits) return v[OW-1:0];
      return v[BW-1] ? {1'b1, {(OW-1){1'b0}}} : {1'b0, {(OW-1){1'b1}}};
   endfunction

   // configuration
   logic [imu_bcs_pkg::ALPHA_W-1:0] alpha_accel_ff, alpha_accel_in;
   logic [imu_bcs_pkg::ALPHA_W-1:0] alpha_rate_ff, alpha_rate_in;
   logic [imu_bcs_pkg::COUNT_W-1:0] calib_samples_ff, calib_samples_in;
   logic                            has_mag_ff, has_mag_in;

   always_comb begin
      alpha_accel_in   = alpha_accel_ff;
      alpha_rate_in    = alpha_rate_ff;
      calib_samples_in = calib_samples_ff;
      has_mag_in       = has_mag_ff;
      if (csr_we) begin
         unique case (csr_addr)
            imu_bcs_pkg::CSR_ALPHA_ACCEL:   alpha_accel_in   = csr_wdata;
            imu_bcs_pkg::CSR_ALPHA_RATE:    alpha_rate_in    = csr_wdata;
            imu_bcs_pkg::CSR_CALIB_SAMPLES: calib_samples_in =
                                               csr_wdata[imu_bcs_pkg::COUNT_W-1:0];
            imu_bcs_pkg::CSR_HAS_MAG:       has_mag_in       = csr_wdata[0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_accel_ff   <= imu_bcs_pkg::ALPHA_ONE;
         alpha_rate_ff    <= imu_bcs_pkg::ALPHA_ONE;
         calib_samples_ff <= imu_bcs_pkg::CALIB_RESET;
         has_mag_ff       <= 1'b0;
      end else begin
         alpha_accel_ff   <= alpha_accel_in;
         alpha_rate_ff    <= alpha_rate_in;
         calib_samples_ff <= calib_samples_in;
         has_mag_ff       <= has_mag_in;
      end
   end

   // captured request
   logic [SW-1:0] accel_ff [AX];
   logic [SW-1:0] rate_ff  [AX];
   logic [SW-1:0] field_ff [AX];

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         for (int i = 0; i < AX; i++) begin
            accel_ff[i] <= req_tdata[i*SW +: SW];
            rate_ff[i]  <= req_tdata[(AX+i)*SW +: SW];
            field_ff[i] <= req_tdata[(2*AX+i)*SW +: SW];
         end
      end
   end

   // calibration accumulators and divider
   logic [imu_bcs_pkg::SUM_W-1:0]   sum_ff [AX];
   logic [imu_bcs_pkg::SUM_W-1:0]   sum_in [AX];
   logic [imu_bcs_pkg::SUM_W-1:0]   sum_mag [AX];
   logic [imu_bcs_pkg::DVD_W-1:0]   quotient [AX];
   logic [OW-1:0]                   bias_ff [AX];
   logic [OW-1:0]                   bias_in [AX];
   logic [imu_bcs_pkg::COUNT_W-1:0] count_ff, count_in;
   logic [imu_bcs_pkg::COUNT_W-1:0] target;
   logic [BW-1:0]                   q_signed [AX];

   assign target = (calib_samples_ff == '0) ? imu_bcs_pkg::COUNT_W'(1) : calib_samples_ff;

   always_comb begin
      count_in = count_ff;
      if (cmd.cal_add) count_in = count_ff + 1'b1;
      else if (cmd.bias_write) count_in = '0;
      for (int i = 0; i < AX; i++) begin
         sum_mag[i]  = sum_ff[i][imu_bcs_pkg::SUM_W-1] ? (~sum_ff[i] + 1'b1) : sum_ff[i];
         q_signed[i] = sum_ff[i][imu_bcs_pkg::SUM_W-1] ? (~{1'b0, quotient[i]} + 1'b1)
                                                        : {1'b0, quotient[i]};
         sum_in[i]   = sum_ff[i];
         bias_in[i]  = bias_ff[i];
         if (cmd.cal_add) begin
            sum_in[i] = sum_ff[i] + {{(imu_bcs_pkg::SUM_W-SW){rate_ff[i][SW-1]}}, rate_ff[i]};
         end else if (cmd.bias_write) begin
            sum_in[i]  = '0;
            bias_in[i] = sat_bias(q_signed[i]);
         end
      end
   end

   for (genvar g = 0; g < AX; g++) begin : g_div
      imu_bcs_div_lane u_div (
         .clock    (clock),
         .load     (cmd.div_load),
         .step     (cmd.div_step),
         .dividend ({sum_mag[g], {FW{1'b0}}}),
         .divisor  (count_ff),
         .quotient (quotient[g])
      );
   end

   // filter lanes: accel x/y/z, then rate x/y/z
   logic [OW-1:0]                      cur_ff [LN];
   logic [OW-1:0]                      cur_in [LN];
   logic [OW-1:0]                      prev_ff [LN];
   logic [OW-1:0]                      prev_in [LN];
   logic [SW-1:0]                      mag_ff [AX];
   logic [SW-1:0]                      mag_in [AX];
   logic [imu_bcs_pkg::DIFF_W-1:0]     gyro_diff [AX];
   logic [OW-1:0]                      cur_sel, prev_sel;
   logic [imu_bcs_pkg::ALPHA_W-1:0]    alpha_sel, alpha_eff;
   logic signed [imu_bcs_pkg::DIFF_W-1:0]  lane_diff;
   logic signed [imu_bcs_pkg::ALPHA_W:0]   mul_a;
   logic signed [imu_bcs_pkg::PROD_W-1:0]  prod_ff, prod_in;
   logic [imu_bcs_pkg::PROD_W-1:0]     rounded;
   logic [imu_bcs_pkg::SAT_W-1:0]      filt_sum;

   always_comb begin
      cur_sel   = cur_ff[cmd.axis];
      prev_sel  = prev_ff[cmd.axis];
      alpha_sel = (cmd.axis < imu_bcs_pkg::AXIS_W'(AX)) ? alpha_accel_ff : alpha_rate_ff;
      // weights above one act as one
      alpha_eff = alpha_sel[imu_bcs_pkg::ALPHA_W-1] ? imu_bcs_pkg::ALPHA_ONE : alpha_sel;
      lane_diff = $signed({cur_sel[OW-1], cur_sel}) - $signed({prev_sel[OW-1], prev_sel});
      mul_a     = $signed({1'b0, alpha_eff});
      prod_in   = prod_ff;
      if (cmd.mul) prod_in = lane_diff * mul_a;
      rounded   = prod_ff + imu_bcs_pkg::PROD_W'(1 << (imu_bcs_pkg::ALPHA_FRAC - 1));
      filt_sum  = {{(imu_bcs_pkg::SAT_W-OW){prev_sel[OW-1]}}, prev_sel}
                + rounded[imu_bcs_pkg::PROD_W-1:imu_bcs_pkg::ALPHA_FRAC];

      for (int i = 0; i < AX; i++) begin
         gyro_diff[i] = {rate_ff[i][SW-1], rate_ff[i], {FW{1'b0}}}
                      - {bias_ff[i][OW-1], bias_ff[i]};
         mag_in[i]    = (cmd.prep && has_mag_ff) ? field_ff[i] : mag_ff[i];
      end
      for (int i = 0; i < LN; i++) begin
         cur_in[i]  = cur_ff[i];
         prev_in[i] = prev_ff[i];
      end
      if (cmd.prep) begin
         for (int i = 0; i < AX; i++) begin
            cur_in[i]    = {accel_ff[i], {FW{1'b0}}};
            cur_in[AX+i] = sat_out({{(imu_bcs_pkg::SAT_W-imu_bcs_pkg::DIFF_W)
                                     {gyro_diff[i][imu_bcs_pkg::DIFF_W-1]}}, gyro_diff[i]});
         end
      end
      if (cmd.acc) prev_in[cmd.axis] = sat_out(filt_sum);
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      for (int i = 0; i < LN; i++) cur_ff[i] <= cur_in[i];
   end

   // model state
   logic done_ff, done_in;

   always_comb begin
      done_in = done_ff;
      if (cmd.capture) done_in = 1'b0;
      else if (cmd.bias_write) done_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         done_ff  <= 1'b0;
         for (int i = 0; i < AX; i++) begin
            sum_ff[i]  <= '0;
            bias_ff[i] <= '0;
            mag_ff[i]  <= '0;
         end
         for (int i = 0; i < LN; i++) prev_ff[i] <= '0;
      end else begin
         count_ff <= count_in;
         done_ff  <= done_in;
         for (int i = 0; i < AX; i++) begin
            sum_ff[i]  <= sum_in[i];
            bias_ff[i] <= bias_in[i];
            mag_ff[i]  <= mag_in[i];
         end
         for (int i = 0; i < LN; i++) prev_ff[i] <= prev_in[i];
      end
   end

   // result register
   logic                            rsp_valid_ff, rsp_valid_in;
   logic                            rsp_user_ff;
   logic [imu_bcs_pkg::RSP_DW-1:0]  rsp_data_ff, rsp_data_in;

   always_comb begin
      for (int i = 0; i < LN; i++) rsp_data_in[i*OW +: OW] = prev_ff[i];
      for (int i = 0; i < AX; i++) rsp_data_in[LN*OW + i*SW +: SW] = mag_ff[i];
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_data_ff <= rsp_data_in;
         rsp_user_ff <= done_ff;
      end
   end

   assign rsp_tvalid      = rsp_valid_ff;
   assign rsp_tdata       = rsp_data_ff;
   assign rsp_tuser       = rsp_user_ff;
   assign status.cmd_in   = req_tuser;
   assign status.reached  = count_ff >= target;
   assign status.rsp_busy = rsp_valid_ff && !rsp_tready;

`ifndef NO_ASSERTIONS
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> !(rsp_valid_ff && !rsp_tready))
      else $error("result register overwritten while stalled");

   a_bias_clears: assert property (@(posedge clock) disable iff (reset)
      cmd.bias_write |=> (count_ff == '0) && (sum_ff[0] == '0) && done_ff)
      else $error("bias update did not clear the accumulators");

   a_done_clear: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> !done_ff)
      else $error("completion flag carried into a new request");
`endif

endmodule

`default_nettype wire
